// ===== hw/rtl/m3i_pkg.sv =====
package m3i_pkg;

  // Matrix elements per transfer, row-major.
  localparam int unsigned N_ELEM = 9;

  // Flag positions in out_tuser.
  localparam int unsigned FLAG_SINGULAR = 0;
  localparam int unsigned FLAG_OVERFLOW = 1;
  localparam int unsigned USER_W        = 2;

  // Adjugate lane wiring: entry k = +/- (a[X]*a[Y] - a[S]*a[T]),
  // element index is row*3 + column. Lane k feeds output element k.
  localparam int unsigned COF_X [N_ELEM] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int unsigned COF_Y [N_ELEM] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam int unsigned COF_S [N_ELEM] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
  localparam int unsigned COF_T [N_ELEM] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
  localparam bit          COF_NEG [N_ELEM] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};

endpackage

// ===== hw/rtl/m3i_cof.sv =====
module m3i_cof import m3i_pkg::*; #(
  parameter int ELEM_WIDTH = 32,
  parameter bit NEG        = 1'b0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [ELEM_WIDTH-1:0]   x,
  input  logic signed [ELEM_WIDTH-1:0]   y,
  input  logic signed [ELEM_WIDTH-1:0]   s,
  input  logic signed [ELEM_WIDTH-1:0]   t,
  output logic signed [2*ELEM_WIDTH:0]   cof
);

  localparam int PW = 2 * ELEM_WIDTH;
  localparam int CW = 2 * ELEM_WIDTH + 1;

  logic signed [PW-1:0] p1_r;
  logic signed [PW-1:0] p2_r;
  logic signed [CW-1:0] cof_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= x * y;
      p2_r <= s * t;
      if (NEG) begin
        cof_r <= CW'(p2_r) - CW'(p1_r);
      end else begin
        cof_r <= CW'(p1_r) - CW'(p2_r);
      end
    end
  end

  assign cof = cof_r;

endmodule

// ===== hw/rtl/m3i_det.sv =====
module m3i_det import m3i_pkg::*; #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ELEM_WIDTH-1:0]     a0,
  input  logic signed [ELEM_WIDTH-1:0]     a1,
  input  logic signed [ELEM_WIDTH-1:0]     a2,
  input  logic signed [2*ELEM_WIDTH:0]     c0,
  input  logic signed [2*ELEM_WIDTH:0]     c1,
  input  logic signed [2*ELEM_WIDTH:0]     c2,
  output logic signed [3*ELEM_WIDTH+2:0]   det
);

  localparam int CW = 2 * ELEM_WIDTH + 1;
  localparam int HW = CW - ELEM_WIDTH;
  localparam int DW = 3 * ELEM_WIDTH + 3;
  localparam int QW = ELEM_WIDTH + HW;

  logic signed [ELEM_WIDTH-1:0] a_w [3];
  logic signed [CW-1:0]         c_w [3];
  logic signed [QW-1:0]         lo_r [3];
  logic signed [QW-1:0]         hi_r [3];
  logic signed [DW-1:0]         term_r [3];
  logic signed [DW-1:0]         det_r;

  assign a_w[0] = a0;
  assign a_w[1] = a1;
  assign a_w[2] = a2;
  assign c_w[0] = c0;
  assign c_w[1] = c1;
  assign c_w[2] = c2;

  // Split each adjugate entry in two halves, one narrow multiply each.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lo_r[j]   <= a_w[j] * $signed({1'b0, c_w[j][ELEM_WIDTH-1:0]});
        hi_r[j]   <= a_w[j] * $signed(c_w[j][CW-1:ELEM_WIDTH]);
        term_r[j] <= (DW'(hi_r[j]) <<< ELEM_WIDTH) + DW'(lo_r[j]);
      end
      det_r <= term_r[0] + term_r[1] + term_r[2];
    end
  end

  assign det = det_r;

endmodule

// ===== hw/rtl/m3i_div.sv =====
module m3i_div import m3i_pkg::*; #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [2*ELEM_WIDTH:0]     cof,
  input  logic signed [3*ELEM_WIDTH+2:0]   det,
  output logic        [ELEM_WIDTH-1:0]     q,
  output logic                             ovf
);

  localparam int E   = ELEM_WIDTH;
  localparam int CW  = 2 * E + 1;
  localparam int DW  = 3 * E + 3;
  localparam int NW  = CW + 2 * FRAC_BITS;
  localparam int WW  = (NW > DW + E) ? NW : DW + E;

  logic [CW-1:0] cmag;
  logic [DW-1:0] dmag;

  logic [WW-1:0] nm0_r;
  logic [WW-1:0] dn0_r;
  logic          ng0_r;

  logic [WW-1:0] rem_r [E+1];
  logic [WW-1:0] den_r [E+1];
  logic [E-1:0]  q_r   [E+1];
  logic          neg_r [E+1];
  logic          hi_r  [E+1];

  logic [E-1:0]  q_out_r;
  logic          ovf_r;

  assign cmag = cof[CW-1] ? CW'(-cof) : CW'(cof);
  assign dmag = det[DW-1] ? DW'(-det) : DW'(det);

  // Magnitudes, numerator scaled up by two fraction widths.
  always_ff @(posedge clk) begin
    if (en) begin
      nm0_r <= {{(WW-CW){1'b0}}, cmag} << (2 * FRAC_BITS);
      dn0_r <= {{(WW-DW){1'b0}}, dmag};
      ng0_r <= cof[CW-1] ^ det[DW-1];
    end
  end

  // Quotient of 2^E or more saturates whatever the low bits are.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= nm0_r;
      den_r[0] <= dn0_r;
      q_r[0]   <= '0;
      neg_r[0] <= ng0_r;
      hi_r[0]  <= nm0_r >= (dn0_r << E);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar i = 1; i <= E; i++) begin : g_bit
    localparam int K = E - i;
    localparam logic [E-1:0] QBIT = {{(E-1){1'b0}}, 1'b1} << K;
    logic [WW-1:0] dsh;
    logic          ge;
    logic [WW-1:0] rem_nxt;
    logic [E-1:0]  q_nxt;

    assign dsh     = den_r[i-1] << K;
    assign ge      = rem_r[i-1] >= dsh;
    assign rem_nxt = ge ? rem_r[i-1] - dsh : rem_r[i-1];
    assign q_nxt   = ge ? (q_r[i-1] | QBIT) : q_r[i-1];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        den_r[i] <= den_r[i-1];
        q_r[i]   <= q_nxt;
        neg_r[i] <= neg_r[i-1];
        hi_r[i]  <= hi_r[i-1];
      end
    end
  end

  // Saturate to the signed element range and apply the sign.
  logic          neg_eff;
  logic [E:0]    lim;
  logic          sat;
  logic [E-1:0]  mag;
  logic [E-1:0]  q_nxt;

  assign neg_eff = neg_r[E] && (hi_r[E] || (q_r[E] != '0));
  assign lim     = neg_eff ? {2'b01, {(E-1){1'b0}}} : {2'b00, {(E-1){1'b1}}};
  assign sat     = hi_r[E] || ({1'b0, q_r[E]} > lim);
  assign mag     = sat ? lim[E-1:0] : q_r[E];
  assign q_nxt   = neg_eff ? (~mag + {{(E-1){1'b0}}, 1'b1}) : mag;

  always_ff @(posedge clk) begin
    if (en) begin
      q_out_r <= q_nxt;
      ovf_r   <= sat;
    end
  end

  assign q   = q_out_r;
  assign ovf = ovf_r;

endmodule

// ===== hw/rtl/matrix3x3_inverse.sv =====
// 3x3 fixed-point matrix inverse by the adjugate.
//
// in_*  : one matrix per transfer, nine signed elements, row-major, each
//         ELEM_WIDTH bits with FRAC_BITS fraction bits.
// out_* : the inverse in the same format, plus singular and overflow flags.
//         A zero determinant gives all-zero elements and singular set;
//         quotients beyond the element range saturate and set overflow.
//
// Nine adjugate lanes run side by side; three of them (adjugate column 0)
// feed the determinant unit, and nine divider lanes then divide by it, one
// quotient bit per stage. A final stage merges the lanes and the flags into
// the output.
//
// Throughput: one matrix per cycle unless the receiver stalls.
// Reset empties the pipeline; results in flight are dropped.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready drops; nothing is lost or repeated.
module matrix3x3_inverse import m3i_pkg::*; #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  localparam int TDW = ((N_ELEM * ELEM_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [TDW-1:0]    in_tdata,   // in_r0c0, in_r0c1, ... in_r2c2, zero pad
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [TDW-1:0]    out_tdata,  // out_r0c0, out_r0c1, ... out_r2c2, zero pad
  output logic [USER_W-1:0] out_tuser   // singular, overflow
);

  localparam int E       = ELEM_WIDTH;
  localparam int CW      = 2 * E + 1;
  localparam int DW      = 3 * E + 3;
  localparam int DIV_LAT = E + 3;
  localparam int LAT     = E + 10;

  logic                 en;
  logic [LAT-1:0]       vld_r;

  logic signed [E-1:0]  a_r   [N_ELEM];
  logic signed [E-1:0]  r0a_r [3];
  logic signed [E-1:0]  r0b_r [3];
  logic signed [CW-1:0] cof_w [N_ELEM];
  logic signed [CW-1:0] cd1_r [N_ELEM];
  logic signed [CW-1:0] cd2_r [N_ELEM];
  logic signed [CW-1:0] cd3_r [N_ELEM];
  logic signed [DW-1:0] det_w;
  logic [DIV_LAT-1:0]   sing_r;

  logic [E-1:0]         q_w   [N_ELEM];
  logic [N_ELEM-1:0]    ovf_w;

  logic [E-1:0]         out_val_r [N_ELEM];
  logic                 out_sing_r;
  logic                 out_ovf_r;

  // Advance everything when the output register is free or being taken.
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Capture the elements of the incoming transfer.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_ELEM; i++) begin
        a_r[i] <= $signed(in_tdata[i*E +: E]);
      end
    end
  end

  // Adjugate lanes.
  for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
    m3i_cof #(
      .ELEM_WIDTH (E),
      .NEG        (COF_NEG[k])
    ) u_cof (
      .clk (clk),
      .en  (en),
      .x   (a_r[COF_X[k]]),
      .y   (a_r[COF_Y[k]]),
      .s   (a_r[COF_S[k]]),
      .t   (a_r[COF_T[k]]),
      .cof (cof_w[k])
    );
  end

  // Hold row 0 until its adjugate column is ready, and hold the adjugate
  // until the determinant is ready.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        r0a_r[j] <= a_r[j];
        r0b_r[j] <= r0a_r[j];
      end
      for (int i = 0; i < N_ELEM; i++) begin
        cd1_r[i] <= cof_w[i];
        cd2_r[i] <= cd1_r[i];
        cd3_r[i] <= cd2_r[i];
      end
    end
  end

  // Determinant by expansion along row 0 against adjugate column 0.
  m3i_det #(
    .ELEM_WIDTH (E)
  ) u_det (
    .clk (clk),
    .en  (en),
    .a0  (r0b_r[0]),
    .a1  (r0b_r[1]),
    .a2  (r0b_r[2]),
    .c0  (cof_w[0]),
    .c1  (cof_w[3]),
    .c2  (cof_w[6]),
    .det (det_w)
  );

  // Divider lanes.
  for (genvar k = 0; k < N_ELEM; k++) begin : g_div
    m3i_div #(
      .ELEM_WIDTH (E),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (en),
      .cof (cd3_r[k]),
      .det (det_w),
      .q   (q_w[k]),
      .ovf (ovf_w[k])
    );
  end

  // Carry the singular mark alongside the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= {sing_r[DIV_LAT-2:0], det_w == '0};
    end
  end

  // Merge lanes and flags into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_ELEM; i++) begin
        out_val_r[i] <= sing_r[DIV_LAT-1] ? '0 : q_w[i];
      end
      out_sing_r <= sing_r[DIV_LAT-1];
      out_ovf_r  <= !sing_r[DIV_LAT-1] && (|ovf_w);
    end
  end

  assign out_tvalid = vld_r[LAT-1];

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < N_ELEM; i++) begin
      out_tdata[i*E +: E] = out_val_r[i];
    end
  end

  always_comb begin
    out_tuser                = '0;
    out_tuser[FLAG_SINGULAR] = out_sing_r;
    out_tuser[FLAG_OVERFLOW] = out_ovf_r;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import m3i_pkg::*;

  localparam int EW  = 32;
  localparam int FB  = 16;
  localparam int TDW = ((N_ELEM * EW + 7) / 8) * 8;
  localparam int LATENCY = EW + 10;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [TDW-1:0]    data;
    logic [USER_W-1:0] user;
  } inverse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDW-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;

  inverse_t expected_inverses[$];
  int  fail_count = 0;
  longint cycle_count = 0;
  bit  hold_off = 1'b0;   // long receiver stall requested by a test
  bit  no_gaps  = 1'b0;   // stretches with no idling on either side

  always #2 clk = ~clk;

  matrix3x3_inverse uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Short gaps mostly, a long one now and then.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Exact adjugate inverse. Products need at most 96 bits; the shifted
  // numerator 65 + 32 bits, so 200-bit signed math is exact throughout.
  function automatic inverse_t predict_inverse(logic [TDW-1:0] m);
    logic signed [199:0] a [9];
    logic signed [199:0] det, cof, num, den, q, hi, lo;
    logic [EW-1:0] elem;
    inverse_t r;
    bit ovf;
    r = '0;
    ovf = 1'b0;
    for (int k = 0; k < 9; k++) a[k] = $signed(m[k*EW +: EW]);
    det = a[0]*a[4]*a[8] + a[1]*a[5]*a[6] + a[2]*a[3]*a[7]
        - a[2]*a[4]*a[6] - a[1]*a[3]*a[8] - a[0]*a[5]*a[7];
    if (det == 0) begin
      r.user[FLAG_SINGULAR] = 1'b1;
      return r;
    end
    hi = (200'sd1 <<< (EW-1)) - 1;
    lo = -(200'sd1 <<< (EW-1));
    for (int k = 0; k < 9; k++) begin
      cof = a[COF_X[k]]*a[COF_Y[k]] - a[COF_S[k]]*a[COF_T[k]];
      if (COF_NEG[k]) cof = -cof;
      num = cof <<< (2*FB);
      den = det;
      q = num / den;   // truncates toward zero
      if (q > hi) begin q = hi; ovf = 1'b1; end
      else if (q < lo) begin q = lo; ovf = 1'b1; end
      elem = q[EW-1:0];
      r.data[k*EW +: EW] = elem;
    end
    r.user[FLAG_OVERFLOW] = ovf;
    return r;
  endfunction

  // Offer one matrix, hold it until the transfer, record its expectation.
  // Drop valid only when a gap follows, so back-to-back items keep it high.
  task automatic send_matrix(logic [TDW-1:0] m);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tdata  <= m;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_inverses.push_back(predict_inverse(m));
    @(negedge clk);
  endtask

  function automatic logic [TDW-1:0] pack9(logic [EW-1:0] e [9]);
    logic [TDW-1:0] m;
    m = '0;
    for (int k = 0; k < 9; k++) m[k*EW +: EW] = e[k];
    return m;
  endfunction

  function automatic logic [EW-1:0] rand_elem(int mode);
    case (mode)
      0: return $urandom;
      1: return {{(EW-20){1'b0}}, 20'($urandom)} - (1 << 19);
      2: return $signed(EW'($urandom_range(0, 8))) - 4 <<< FB;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // Receiver: random stalls, plus the long hold-off when requested.
  always @(negedge clk) begin
    if (hold_off || (!no_gaps && $urandom_range(0, 99) < 25)) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    inverse_t exp_r;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_inverses.size() == 0) begin
        $error("result with no matrix outstanding");
        fail_count = fail_count + 1;
      end else begin
        exp_r = expected_inverses.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_tdata[k*EW +: EW] !== exp_r.data[k*EW +: EW]) begin
            $error("out_r%0dc%0d exp %h got %h", k/3, k%3,
                   exp_r.data[k*EW +: EW], out_tdata[k*EW +: EW]);
            fail_count = fail_count + 1;
          end
        if (out_tuser[FLAG_SINGULAR] !== exp_r.user[FLAG_SINGULAR]) begin
          $error("singular exp %b got %b", exp_r.user[FLAG_SINGULAR],
                 out_tuser[FLAG_SINGULAR]);
          fail_count = fail_count + 1;
        end
        if (out_tuser[FLAG_OVERFLOW] !== exp_r.user[FLAG_OVERFLOW]) begin
          $error("overflow exp %b got %b", exp_r.user[FLAG_OVERFLOW],
                 out_tuser[FLAG_OVERFLOW]);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [EW-1:0] e [9];
    logic [EW-1:0] one, big_v;
    one = 1 << FB;
    // identity, scaled identity
    e = '{one, 0, 0, 0, one, 0, 0, 0, one}; send_matrix(pack9(e));
    e = '{2*one, 0, 0, 0, -4*one, 0, 0, 0, one/2}; send_matrix(pack9(e));
    // all zero and rank-deficient: singular
    e = '{default: 0}; send_matrix(pack9(e));
    e = '{one, 2*one, 3*one, 2*one, 4*one, 6*one, 1, 5, 9}; send_matrix(pack9(e));
    // tiny determinant: saturation both ways
    e = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(pack9(e));
    e = '{-1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(pack9(e));
    // extremes of the field
    e = '{default: 32'h7fffffff}; send_matrix(pack9(e));
    e = '{default: 32'h80000000}; send_matrix(pack9(e));
    e = '{32'h80000000, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'hffffffff};
    send_matrix(pack9(e));
    e = '{32'hffffffff, 32'h7fffffff, 32'h80000000, 1, 32'h80000000,
          32'h7fffffff, 32'h7fffffff, 1, 32'hffffffff};
    send_matrix(pack9(e));
    // lower-left element matters for the adjugate row 2, column 0 entry
    e = '{one, 0, 0, 0, one, 0, 3*one, 0, one}; send_matrix(pack9(e));
    e = '{one, 0, 5*one, 0, one, 0, 0, 0, one}; send_matrix(pack9(e));
    // results that truncate: a third-scaled identity and a dense matrix
    e = '{3*one, 0, 0, 0, 3*one, 0, 0, 0, -3*one}; send_matrix(pack9(e));
    big_v = 32'h00010001;
    e = '{big_v, one, 0, one, big_v, 7, -5, 3, big_v}; send_matrix(pack9(e));
  endtask

  task automatic test_random(int count);
    logic [EW-1:0] e [9];
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++)
        e[k] = rand_elem(mode < 3 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3);
      if (mode == 8) e[6 + $urandom_range(0, 2)] = 0;
      send_matrix(pack9(e));
      if (n % 300 == 150) no_gaps = ~no_gaps;
    end
    no_gaps = 1'b0;
  endtask

  // Stall the receiver while the sender keeps offering, so the pipe fills.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(posedge clk);
        @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    no_gaps = 1'b1;
    test_random(120);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(1700);
    drain();
    if (fail_count == 0 && expected_inverses.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
